>>> src/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  // field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]        COLOUR_RESET = 8'h07;

  // register index of text_colour, taken from paddr[2]
  localparam logic REG_TEXT_COLOUR = 1'b0;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scroll;
  } cursor_step_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    int lin;
    lin = int'(row) * COLUMNS + int'(col);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/ctc_ram.sv
`default_nettype none

module ctc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/ctc_cursor.sv
`default_nettype none

module ctc_cursor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic                       newline,
  output logic [ctc_pkg::ROW_W-1:0]       row,
  output logic [ctc_pkg::COL_W-1:0]       col,
  output logic [ctc_pkg::ADDR_W-1:0]      addr,
  output ctc_pkg::cursor_step_t           next
);

  logic [ctc_pkg::COL_W:0] col_inc;
  logic [ctc_pkg::ROW_W:0] row_inc;
  logic                    wrap;

  assign col_inc = {1'b0, col} + 1'b1;
  assign wrap    = newline || (col_inc == (ctc_pkg::COL_W+1)'(ctc_pkg::COLUMNS));
  assign row_inc = {1'b0, row} + 1'b1;
  assign addr    = ctc_pkg::cell_addr(row, col);

  always_comb begin
    next.scroll = 1'b0;
    next.row    = row;
    next.col    = col_inc[ctc_pkg::COL_W-1:0];
    if (wrap) begin
      next.col = '0;
      if (row_inc == (ctc_pkg::ROW_W+1)'(ctc_pkg::ROWS)) begin
        // past the bottom row: scroll and park at the bottom row
        next.scroll = 1'b1;
        next.row    = ctc_pkg::ROW_W'(ctc_pkg::ROWS - 1);
      end else begin
        next.row = row_inc[ctc_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (step) begin
      row <= next.row;
      col <= next.col;
    end
  end

endmodule

`default_nettype wire

>>> src/text_console_cursor_scroll.sv
`default_nettype none

// text console writer with an 80 by 25 store of 16-bit cells (colour high, char low)
// input stream: s_tuser is the operation (0 put character, 1 read cell),
//   s_tdata carries char_code, read_row and read_col
// output stream: one transaction per input, cell_value, cursor row/col after the
//   item and a scrolled flag
// config: APB register text_colour at byte address 0, colour of new characters
// sequencing: a put writes the store, then the result state loads the output register;
//   a read waits out the registered read of the cell ram before the result state;
//   a put that scrolls walks the ram copying one cell per cycle through the
//   single read and write port, 1920 cells in all
// reset: the cursor goes home, the colour returns to 0x07, and a clearing pass
//   writes 0x0720 to all 2000 cells, one per cycle; no input transaction is
//   taken during the pass, config writes are
// the output register holds a finished result while the next input transaction
//   is taken; when the receiver stalls, the block finishes that item and then
//   waits with its result until the output register frees up
module text_console_cursor_scroll (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic        s_tuser,   // operation[0]
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // cell_value[15:0], cursor_row[20:16],
                                      // cursor_col[27:21], scrolled[28]
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RDATA  = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state;

  // config register
  logic [7:0] text_colour;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ctc_pkg::REG_TEXT_COLOUR) ? {24'd0, text_colour} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour <= ctc_pkg::COLOUR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ctc_pkg::REG_TEXT_COLOUR) begin
      text_colour <= pwdata[7:0];
    end
  end

  // input unpack
  logic                        in_op;
  logic [ctc_pkg::CHAR_W-1:0]  in_char;
  logic [ctc_pkg::ROW_W-1:0]   in_row;
  logic [ctc_pkg::COL_W-1:0]   in_col;
  logic                        accept;
  logic                        is_put;
  logic                        is_newline;
  logic                        rd_in_range;

  assign in_op       = s_tuser;
  assign in_char     = s_tdata[7:0];
  assign in_row      = s_tdata[12:8];
  assign in_col      = s_tdata[19:13];
  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign is_put      = !in_op;
  assign is_newline  = (in_char == ctc_pkg::NEWLINE_CODE);
  assign rd_in_range = (int'(in_row) < ctc_pkg::ROWS) && (int'(in_col) < ctc_pkg::COLUMNS);

  // cursor unit
  logic [ctc_pkg::ROW_W-1:0]  cur_row;
  logic [ctc_pkg::COL_W-1:0]  cur_col;
  logic [ctc_pkg::ADDR_W-1:0] cur_addr;
  ctc_pkg::cursor_step_t      cur_next;

  ctc_cursor u_cursor (
    .clk     (clk),
    .rst     (rst),
    .step    (accept && is_put),
    .newline (is_newline),
    .row     (cur_row),
    .col     (cur_col),
    .addr    (cur_addr),
    .next    (cur_next)
  );

  // cell store
  logic                       ram_we;
  logic [ctc_pkg::ADDR_W-1:0] ram_waddr;
  logic [ctc_pkg::CELL_W-1:0] ram_wdata;
  logic [ctc_pkg::ADDR_W-1:0] ram_raddr;
  logic [ctc_pkg::CELL_W-1:0] ram_rdata;

  ctc_ram #(
    .WIDTH (ctc_pkg::CELL_W),
    .DEPTH (ctc_pkg::CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sweep counters: clearing pass and scroll copy
  logic [ctc_pkg::ADDR_W-1:0] clr_addr;
  logic [ctc_pkg::ADDR_W-1:0] scan;
  logic                       scan_more;
  logic                       copy_pend;
  logic [ctc_pkg::ADDR_W-1:0] copy_addr;

  assign scan_more = (scan != ctc_pkg::ADDR_W'(ctc_pkg::COPY_CELLS));

  // ram port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {text_colour, in_char};
    ram_raddr = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = ctc_pkg::BLANK_CELL;
      end
      ST_IDLE: begin
        ram_we = accept && is_put && !is_newline;
        if (rd_in_range) begin
          ram_raddr = ctc_pkg::cell_addr(in_row, in_col);
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell fetched last cycle
        ram_raddr = scan + ctc_pkg::ADDR_W'(ctc_pkg::COLUMNS);
        ram_we    = copy_pend;
        ram_waddr = copy_addr;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // result held until the output register is free
  logic [ctc_pkg::CELL_W-1:0] res_cell;
  logic [ctc_pkg::ROW_W-1:0]  res_row;
  logic [ctc_pkg::COL_W-1:0]  res_col;
  logic                       res_scroll;
  logic                       res_in_range;
  logic                       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      scan      <= '0;
      copy_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      copy_pend <= (state == ST_SCROLL) && scan_more;
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ctc_pkg::ADDR_W'(ctc_pkg::CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (!is_put) begin
              state <= ST_RDATA;
            end else if (cur_next.scroll) begin
              scan  <= '0;
              state <= ST_SCROLL;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_RDATA: begin
          state <= ST_RESULT;
        end
        ST_SCROLL: begin
          if (scan_more) begin
            scan <= scan + 1'b1;
          end else if (!copy_pend) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_addr <= scan;
    if (accept) begin
      res_cell     <= '0;
      res_in_range <= rd_in_range;
      if (is_put) begin
        res_row    <= cur_next.row;
        res_col    <= cur_next.col;
        res_scroll <= cur_next.scroll;
      end else begin
        res_row    <= cur_row;
        res_col    <= cur_col;
        res_scroll <= 1'b0;
      end
    end
    if (state == ST_RDATA) begin
      res_cell <= res_in_range ? ram_rdata : '0;
    end
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {3'd0, res_scroll, res_col, res_row, res_cell};
    end
  end

endmodule

`default_nettype wire
